// ----- rtl/scancode_to_ascii_line_buffer_top_assert.svh -----
// Assertion macros used by the line buffer top.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SCANCODE_TO_ASCII_LINE_BUFFER_TOP_ASSERT_SVH
`define SCANCODE_TO_ASCII_LINE_BUFFER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define SCTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SCTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCTA_ASSERT_IMP(lbl, ante, cons, msg)
`define SCTA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/scta_pkg.sv -----
package scta_pkg;

  // Line store geometry
  localparam int BUF_DEPTH = 128;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int FILL_W    = ($clog2(BUF_DEPTH + 1) > 8) ? $clog2(BUF_DEPTH + 1) : 8;

  // Fixed field widths
  localparam int CHAR_W = 8;
  localparam int CODE_W = 8;
  localparam int RIDX_W = 7;
  localparam int LCNT_W = 16;
  localparam int SWI_W  = 2;
  localparam int MAP_N  = 64;

  // Request opcodes
  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } scta_op_t;

  // Set-1 scancodes
  localparam logic [CODE_W-1:0] SC_ESC        = 8'h01;
  localparam logic [CODE_W-1:0] SC_BKSP       = 8'h0E;
  localparam logic [CODE_W-1:0] SC_TAB        = 8'h0F;
  localparam logic [CODE_W-1:0] SC_ENTER      = 8'h1C;
  localparam logic [CODE_W-1:0] SC_CTRL_MK    = 8'h1D;
  localparam logic [CODE_W-1:0] SC_KEY_L      = 8'h26;
  localparam logic [CODE_W-1:0] SC_LSHIFT_MK  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MK  = 8'h36;
  localparam logic [CODE_W-1:0] SC_KP_STAR    = 8'h37;
  localparam logic [CODE_W-1:0] SC_ALT_MK     = 8'h38;
  localparam logic [CODE_W-1:0] SC_CAPS_MK    = 8'h3A;
  localparam logic [CODE_W-1:0] SC_F1         = 8'h3B;
  localparam logic [CODE_W-1:0] SC_F3         = 8'h3D;
  localparam logic [CODE_W-1:0] SC_CTRL_BRK   = 8'h9D;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [CODE_W-1:0] SC_ALT_BRK    = 8'hB8;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

  // Unshifted keymap, codes 0x00..0x3F
  localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_N] = '{
    8'h00, 8'h00, "1",   "2",   "3",   "4",   "5",   "6",
    "7",   "8",   "9",   "0",   "-",   "=",   8'h00, 8'h00,
    "q",   "w",   "e",   "r",   "t",   "y",   "u",   "i",
    "o",   "p",   "[",   "]",   8'h00, 8'h00, "a",   "s",
    "d",   "f",   "g",   "h",   "j",   "k",   "l",   ";",
    8'h27, 8'h60, 8'h00, 8'h5C, "z",   "x",   "c",   "v",
    "b",   "n",   "m",   ",",   ".",   "/",   8'h00, "*",
    8'h00, " ",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Shifted keymap, codes 0x00..0x3F
  localparam logic [CHAR_W-1:0] SHIFT_MAP [MAP_N] = '{
    8'h00, 8'h00, "!",   "@",   "#",   "$",   "%",   "^",
    "&",   "*",   "(",   ")",   "_",   "+",   8'h00, 8'h00,
    "Q",   "W",   "E",   "R",   "T",   "Y",   "U",   "I",
    "O",   "P",   "{",   "}",   8'h00, 8'h00, "A",   "S",
    "D",   "F",   "G",   "H",   "J",   "K",   "L",   ":",
    8'h22, 8'h7E, 8'h00, 8'h7C, "Z",   "X",   "C",   "V",
    "B",   "N",   "M",   "<",   ">",   "?",   8'h00, "*",
    8'h00, " ",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Store access for one request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              rd_in_range;
  } scta_mem_req_t;

  // Result fields known at accept time
  typedef struct packed {
    logic              op_read;
    logic              bksp;
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              clear_screen;
    logic              switch_valid;
    logic [SWI_W-1:0]  switch_index;
    logic [FILL_W-1:0] fill_level;
    logic [LCNT_W-1:0] line_count;
  } scta_res_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

// ----- rtl/scancode_to_ascii_line_buffer_top.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_op, in_scan_code, in_read_index
// out      out_valid / out_ready  out_echo_valid .. out_read_data (one per request)
//
// The store is read and state updated at accept; the result register follows stage one.
// One request per cycle is sustained while out_ready is high; the line store RAM (one
// write, one read port, read-first) is touched only at accept, so back-to-back requests
// never collide. Reset clears key flags, counters and the per-entry valid bits.
// A stalled result holds stage one; in_ready drops only when both stages are full.
`include "scancode_to_ascii_line_buffer_top_assert.svh"

module scancode_to_ascii_line_buffer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [scta_pkg::CODE_W-1:0]   in_scan_code,
  input  logic [scta_pkg::RIDX_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_echo_valid,
  output logic [scta_pkg::CHAR_W-1:0]   out_echo_char,
  output logic                          out_erase_echo,
  output logic                          out_clear_screen,
  output logic                          out_switch_valid,
  output logic [scta_pkg::SWI_W-1:0]    out_switch_index,
  output logic [7:0]                    out_fill_level,
  output logic [scta_pkg::LCNT_W-1:0]   out_line_count,
  output logic [scta_pkg::CHAR_W-1:0]   out_read_data
);
  import scta_pkg::*;

  logic              accept;
  logic              s1_adv;
  scta_mem_req_t     mem_req;
  scta_res_t         res;
  logic [CHAR_W-1:0] rdata;

  logic [BUF_DEPTH-1:0] vld_r;
  logic                 s1_valid_r;
  scta_res_t            s1_res_r;
  logic                 s1_vbit_r;
  logic                 out_valid_r;

  logic              erase_nxt;
  logic [CHAR_W-1:0] rd_nxt;

  // Handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  scta_kbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_op),
    .scan_code  (in_scan_code),
    .read_index (in_read_index),
    .mem_req    (mem_req),
    .res        (res)
  );

  scta_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // Entry written since reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_req.we) begin
      vld_r[mem_req.waddr] <= 1'b1;
    end
  end

  // Stage one: waits for the store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r  <= res;
      s1_vbit_r <= vld_r[mem_req.raddr] && mem_req.rd_in_range;
    end
  end

  // Merge store data into the result
  assign erase_nxt = s1_res_r.bksp && s1_vbit_r && (rdata != CH_NUL);
  assign rd_nxt    = (s1_res_r.op_read && s1_vbit_r) ? rdata : CH_NUL;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_echo_valid   <= s1_res_r.echo_valid;
      out_echo_char    <= s1_res_r.echo_char;
      out_erase_echo   <= erase_nxt;
      out_clear_screen <= s1_res_r.clear_screen;
      out_switch_valid <= s1_res_r.switch_valid;
      out_switch_index <= s1_res_r.switch_index;
      out_fill_level   <= s1_res_r.fill_level[7:0];
      out_line_count   <= s1_res_r.line_count;
      out_read_data    <= rd_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  `SCTA_ASSERT_IMP(a_store_write_on_accept, mem_req.we, accept, "store written without accept")
  `SCTA_ASSERT_NXT(a_accept_fills_s1, accept, s1_valid_r, "accepted request lost before stage one")
  `SCTA_ASSERT_IMP(a_fill_bound, s1_valid_r, s1_res_r.fill_level <= FILL_W'(BUF_DEPTH), "fill level beyond store depth")
  `SCTA_ASSERT_IMP(a_one_action, out_valid_r, $onehot0({out_echo_valid, out_erase_echo, out_clear_screen, out_switch_valid}), "more than one action in a result")

endmodule

// ----- rtl/scta_ram.sv -----
module scta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/scta_kbd_ctrl.sv -----
module scta_kbd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          op,
  input  logic [scta_pkg::CODE_W-1:0]   scan_code,
  input  logic [scta_pkg::RIDX_W-1:0]   read_index,
  output scta_pkg::scta_mem_req_t       mem_req,
  output scta_pkg::scta_res_t           res
);
  import scta_pkg::*;

  logic              lshift_r, lshift_nxt;
  logic              rshift_r, rshift_nxt;
  logic              caps_r, caps_nxt;
  logic              ctrl_r, ctrl_nxt;
  logic              alt_r, alt_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LCNT_W-1:0] lines_r, lines_nxt;

  logic [CHAR_W-1:0] map_raw;
  logic [CHAR_W-1:0] mapped;
  logic [FILL_W-1:0] bksp_fill;
  scta_mem_req_t     req;

  // Keymap lookup with caps folding on letters
  always_comb begin
    map_raw = (lshift_r || rshift_r) ? SHIFT_MAP[scan_code[5:0]] : PLAIN_MAP[scan_code[5:0]];
    mapped  = (caps_r && is_letter(map_raw)) ? (map_raw ^ CASE_BIT) : map_raw;
  end

  assign bksp_fill = (fill_r != '0) ? (fill_r - FILL_W'(1)) : fill_r;

  // Scancode decode: next flags, counters and store access
  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    caps_nxt   = caps_r;
    ctrl_nxt   = ctrl_r;
    alt_nxt    = alt_r;
    fill_nxt   = fill_r;
    lines_nxt  = lines_r;
    req        = '0;
    res        = '0;

    if (op == OP_READ) begin
      res.op_read     = 1'b1;
      req.raddr       = ADDR_W'(read_index);
      req.rd_in_range = (FILL_W'(read_index) < FILL_W'(BUF_DEPTH));
    end else begin
      unique case (scan_code)
        SC_LSHIFT_MK:  lshift_nxt = 1'b1;
        SC_LSHIFT_BRK: lshift_nxt = 1'b0;
        SC_RSHIFT_MK:  rshift_nxt = 1'b1;
        SC_RSHIFT_BRK: rshift_nxt = 1'b0;
        SC_CAPS_MK:    caps_nxt   = !caps_r;
        SC_CTRL_MK:    ctrl_nxt   = 1'b1;
        SC_CTRL_BRK:   ctrl_nxt   = 1'b0;
        SC_ALT_MK:     alt_nxt    = 1'b1;
        SC_ALT_BRK:    alt_nxt    = 1'b0;
        SC_ENTER: begin
          // Enter may take the last slot
          if (fill_r < FILL_W'(BUF_DEPTH)) begin
            req.we         = 1'b1;
            req.waddr      = fill_r[ADDR_W-1:0];
            req.wdata      = CH_NEWLINE;
            fill_nxt       = fill_r + FILL_W'(1);
            lines_nxt      = lines_r + LCNT_W'(1);
            res.echo_valid = 1'b1;
            res.echo_char  = CH_NEWLINE;
          end
        end
        SC_BKSP: begin
          // Read old entry for the erase check, clear it in the same cycle
          res.bksp        = 1'b1;
          req.we          = 1'b1;
          req.waddr       = bksp_fill[ADDR_W-1:0];
          req.wdata       = CH_NUL;
          req.raddr       = bksp_fill[ADDR_W-1:0];
          req.rd_in_range = 1'b1;
          fill_nxt        = bksp_fill;
        end
        default: begin
          if (ctrl_r && (scan_code == SC_KEY_L)) begin
            res.clear_screen = 1'b1;
          end else if ((scan_code >= SC_F1) && (scan_code <= SC_F3)) begin
            if (alt_r) begin
              res.switch_valid = 1'b1;
              res.switch_index = SWI_W'(scan_code - SC_F1);
            end
          end else if ((scan_code < SC_F1) && (scan_code != SC_ESC) &&
                       (scan_code != SC_TAB) && (scan_code != SC_KP_STAR)) begin
            // Printable key, one slot kept free for enter
            if ((mapped != CH_NUL) && (fill_r < FILL_W'(BUF_DEPTH - 1))) begin
              req.we         = 1'b1;
              req.waddr      = fill_r[ADDR_W-1:0];
              req.wdata      = mapped;
              fill_nxt       = fill_r + FILL_W'(1);
              res.echo_valid = 1'b1;
              res.echo_char  = mapped;
            end
          end
        end
      endcase
    end

    res.fill_level = fill_nxt;
    res.line_count = lines_nxt;
  end

  // Gate store access with the handshake
  always_comb begin
    mem_req    = req;
    mem_req.we = req.we && accept;
    mem_req.re = accept;
  end

  // Keyboard state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      caps_r   <= 1'b0;
      ctrl_r   <= 1'b0;
      alt_r    <= 1'b0;
      fill_r   <= '0;
      lines_r  <= '0;
    end else if (accept) begin
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      caps_r   <= caps_nxt;
      ctrl_r   <= ctrl_nxt;
      alt_r    <= alt_nxt;
      fill_r   <= fill_nxt;
      lines_r  <= lines_nxt;
    end
  end

endmodule
